// ----- src/fvcw_pkg.sv -----
package fvcw_pkg;

	localparam int WHEEL_COLORS = 55;
	localparam int CORDIC_ITERS = 16;
	localparam int ANGLE_W = 16;
	localparam int RAD_W = 17;

	// Pipeline stage counts of the angle, radius and color paths.
	localparam int ANGLE_STAGES = CORDIC_ITERS + 2;
	localparam int RADIUS_STAGES = 4 + RAD_W;
	localparam int COLOR_STAGES = 4;

	// atan(2^-i) in units of 1/65536 turn.
	function automatic logic [13:0] atan_turn(input int i);
		logic [13:0] r;
		case (i)
			0: r = 14'd8192;
			1: r = 14'd4836;
			2: r = 14'd2555;
			3: r = 14'd1297;
			4: r = 14'd651;
			5: r = 14'd326;
			6: r = 14'd163;
			7: r = 14'd81;
			8: r = 14'd41;
			9: r = 14'd20;
			10: r = 14'd10;
			11: r = 14'd5;
			12: r = 14'd3;
			13: r = 14'd1;
			14: r = 14'd1;
			default: r = 14'd0;
		endcase
		return r;
	endfunction

	// Wheel entry as {red, green, blue}.
	function automatic logic [23:0] wheel_rgb(input logic [5:0] k);
		logic [23:0] r;
		case (k)
			6'd0: r = {8'd255, 8'd0, 8'd0};
			6'd1: r = {8'd255, 8'd17, 8'd0};
			6'd2: r = {8'd255, 8'd34, 8'd0};
			6'd3: r = {8'd255, 8'd51, 8'd0};
			6'd4: r = {8'd255, 8'd68, 8'd0};
			6'd5: r = {8'd255, 8'd85, 8'd0};
			6'd6: r = {8'd255, 8'd102, 8'd0};
			6'd7: r = {8'd255, 8'd119, 8'd0};
			6'd8: r = {8'd255, 8'd136, 8'd0};
			6'd9: r = {8'd255, 8'd153, 8'd0};
			6'd10: r = {8'd255, 8'd170, 8'd0};
			6'd11: r = {8'd255, 8'd187, 8'd0};
			6'd12: r = {8'd255, 8'd204, 8'd0};
			6'd13: r = {8'd255, 8'd221, 8'd0};
			6'd14: r = {8'd255, 8'd238, 8'd0};
			6'd15: r = {8'd255, 8'd255, 8'd0};
			6'd16: r = {8'd213, 8'd255, 8'd0};
			6'd17: r = {8'd170, 8'd255, 8'd0};
			6'd18: r = {8'd128, 8'd255, 8'd0};
			6'd19: r = {8'd85, 8'd255, 8'd0};
			6'd20: r = {8'd43, 8'd255, 8'd0};
			6'd21: r = {8'd0, 8'd255, 8'd0};
			6'd22: r = {8'd0, 8'd255, 8'd63};
			6'd23: r = {8'd0, 8'd255, 8'd127};
			6'd24: r = {8'd0, 8'd255, 8'd191};
			6'd25: r = {8'd0, 8'd255, 8'd255};
			6'd26: r = {8'd0, 8'd232, 8'd255};
			6'd27: r = {8'd0, 8'd209, 8'd255};
			6'd28: r = {8'd0, 8'd186, 8'd255};
			6'd29: r = {8'd0, 8'd163, 8'd255};
			6'd30: r = {8'd0, 8'd140, 8'd255};
			6'd31: r = {8'd0, 8'd116, 8'd255};
			6'd32: r = {8'd0, 8'd93, 8'd255};
			6'd33: r = {8'd0, 8'd70, 8'd255};
			6'd34: r = {8'd0, 8'd47, 8'd255};
			6'd35: r = {8'd0, 8'd24, 8'd255};
			6'd36: r = {8'd0, 8'd0, 8'd255};
			6'd37: r = {8'd19, 8'd0, 8'd255};
			6'd38: r = {8'd39, 8'd0, 8'd255};
			6'd39: r = {8'd58, 8'd0, 8'd255};
			6'd40: r = {8'd78, 8'd0, 8'd255};
			6'd41: r = {8'd98, 8'd0, 8'd255};
			6'd42: r = {8'd117, 8'd0, 8'd255};
			6'd43: r = {8'd137, 8'd0, 8'd255};
			6'd44: r = {8'd156, 8'd0, 8'd255};
			6'd45: r = {8'd176, 8'd0, 8'd255};
			6'd46: r = {8'd196, 8'd0, 8'd255};
			6'd47: r = {8'd215, 8'd0, 8'd255};
			6'd48: r = {8'd235, 8'd0, 8'd255};
			6'd49: r = {8'd255, 8'd0, 8'd255};
			6'd50: r = {8'd255, 8'd0, 8'd213};
			6'd51: r = {8'd255, 8'd0, 8'd170};
			6'd52: r = {8'd255, 8'd0, 8'd128};
			6'd53: r = {8'd255, 8'd0, 8'd85};
			6'd54: r = {8'd255, 8'd0, 8'd43};
			default: r = 24'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- src/fvcw_angle.sv -----
module fvcw_angle (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [23:0]              flow_x,
	input  logic signed [23:0]              flow_y,
	output logic [fvcw_pkg::ANGLE_W-1:0]    angle
);

	localparam int N = fvcw_pkg::CORDIC_ITERS;

	logic signed [35:0] x_s [0:N];
	logic signed [35:0] y_s [0:N];
	logic signed [17:0] a_s [0:N];
	logic [1:0]         q_s [0:N];
	logic [fvcw_pkg::ANGLE_W-1:0] angle_q;

	logic signed [35:0] xe, ye, xm, ym;
	logic [1:0]         qm;

	assign xe = 36'(flow_x);
	assign ye = 36'(flow_y);

	// Rotate the vector into the first quadrant (x > 0, y >= 0). The zero vector
	// stays in the first quadrant so that its angle clamps to zero.
	always_comb begin
		if (xe == 0 && ye == 0) begin
			qm = 2'd0; xm = '0;  ym = '0;
		end else if (ye >= 0 && xe > 0) begin
			qm = 2'd0; xm = xe;  ym = ye;
		end else if (xe <= 0 && ye > 0) begin
			qm = 2'd1; xm = ye;  ym = -xe;
		end else if (ye <= 0 && xe < 0) begin
			qm = 2'd2; xm = -xe; ym = -ye;
		end else begin
			qm = 2'd3; xm = -ye; ym = xe;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= xm <<< 8;
			y_s[0] <= ym <<< 8;
			a_s[0] <= '0;
			q_s[0] <= qm;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [35:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					a_s[i+1] <= a_s[i] + 18'(fvcw_pkg::atan_turn(i));
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					a_s[i+1] <= a_s[i] - 18'(fvcw_pkg::atan_turn(i));
				end
			end
		end
	end

	// Clamp the first-quadrant angle and add the quadrant offset.
	always_ff @(posedge clk) begin
		if (en) begin
			if (a_s[N] < 0)
				angle_q <= {q_s[N], 14'd0};
			else if (a_s[N] > 18'sd16383)
				angle_q <= {q_s[N], 14'd16383};
			else
				angle_q <= {q_s[N], a_s[N][13:0]};
		end
	end

	assign angle = angle_q;

endmodule

// ----- src/fvcw_radius.sv -----
module fvcw_radius #(
	parameter int FLOW_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [23:0]            flow_x,
	input  logic signed [23:0]            flow_y,
	input  logic [31:0]                   inv_max_radius,
	output logic [fvcw_pkg::RAD_W-1:0]    rad,
	output logic                          in_unit
);

	localparam int R = fvcw_pkg::RAD_W;

	logic [23:0] ax, ay;
	logic [55:0] pu_s1, pv_s1;
	logic [55:0] su, sv;
	logic [16:0] u_s2, v_s2;
	logic        big_s2, big_s3;
	logic [33:0] uu_s3, vv_s3;
	logic [34:0] sum;

	logic [33:0] n_s [0:R];
	logic [33:0] r_s [0:R];
	logic        in_s [0:R];

	assign ax = flow_x[23] ? 24'(-flow_x) : flow_x;
	assign ay = flow_y[23] ? 24'(-flow_y) : flow_y;
	assign su = pu_s1 >> FLOW_FRAC_BITS;
	assign sv = pv_s1 >> FLOW_FRAC_BITS;
	assign sum = 35'(uu_s3) + 35'(vv_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			pu_s1  <= 56'(ax) * 56'(inv_max_radius);
			pv_s1  <= 56'(ay) * 56'(inv_max_radius);
			u_s2   <= su[16:0];
			v_s2   <= sv[16:0];
			big_s2 <= (su > 56'd65536) || (sv > 56'd65536);
			uu_s3  <= 34'(u_s2) * 34'(u_s2);
			vv_s3  <= 34'(v_s2) * 34'(v_s2);
			big_s3 <= big_s2;
			in_s[0] <= !big_s3 && (sum <= 35'h1_0000_0000);
			n_s[0]  <= (!big_s3 && (sum <= 35'h1_0000_0000)) ? sum[33:0] : '0;
			r_s[0]  <= '0;
		end
	end

	// Integer square root, one result bit per stage.
	for (genvar i = 0; i < R; i++) begin : g_sqrt
		localparam logic [33:0] BIT = 34'(1) << (2 * (R - 1 - i));
		logic [33:0] t;
		assign t = r_s[i] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				in_s[i+1] <= in_s[i];
				if (n_s[i] >= t) begin
					n_s[i+1] <= n_s[i] - t;
					r_s[i+1] <= (r_s[i] >> 1) + BIT;
				end else begin
					n_s[i+1] <= n_s[i];
					r_s[i+1] <= r_s[i] >> 1;
				end
			end
		end
	end

	assign rad = r_s[R][R-1:0];
	assign in_unit = in_s[R];

endmodule

// ----- src/fvcw_color.sv -----
module fvcw_color (
	input  logic                          clk,
	input  logic                          en,
	input  logic [fvcw_pkg::ANGLE_W-1:0]  angle,
	input  logic [fvcw_pkg::RAD_W-1:0]    rad,
	input  logic                          in_unit,
	input  logic                          blank,
	output logic [23:0]                   rgb
);

	localparam int W = fvcw_pkg::WHEEL_COLORS;

	logic [21:0] fk;
	logic [5:0]  k0_s1, k1;
	logic [15:0] f_s1;
	logic [16:0] rad_s1, rad_s2;
	logic        in_s1, in_s2, in_s3;
	logic        bl_s1, bl_s2, bl_s3;
	logic [23:0] c0, c1;
	logic [23:0] col_s2 [0:2];
	logic [40:0] pr_s3 [0:2];
	logic [7:0]  ov_s3 [0:2];
	logic [7:0]  o_s4 [0:2];

	assign fk = 22'(angle) * 22'(W - 1);
	assign k1 = (k0_s1 == 6'(W - 1)) ? 6'd0 : k0_s1 + 6'd1;
	assign c0 = fvcw_pkg::wheel_rgb(k0_s1);
	assign c1 = fvcw_pkg::wheel_rgb(k1);

	always_ff @(posedge clk) begin
		if (en) begin
			k0_s1  <= (fk[21:16] >= 6'(W)) ? 6'(W - 1) : fk[21:16];
			f_s1   <= fk[15:0];
			rad_s1 <= rad;
			in_s1  <= in_unit;
			bl_s1  <= blank;
			rad_s2 <= rad_s1;
			in_s2  <= in_s1;
			bl_s2  <= bl_s1;
			in_s3  <= in_s2;
			bl_s3  <= bl_s2;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_ch
		localparam int HI = 23 - 8 * c;
		logic [40:0] num;
		assign num = {1'b0, 8'd255, 32'd0} - pr_s3[c];
		always_ff @(posedge clk) begin
			if (en) begin
				col_s2[c] <= 24'(24'(c0[HI -: 8]) * (24'h01_0000 - 24'(f_s1))
					+ 24'(c1[HI -: 8]) * 24'(f_s1));
				pr_s3[c] <= 41'(rad_s2) * 41'(24'hFF_0000 - col_s2[c]);
				ov_s3[c] <= 8'((26'(col_s2[c]) * 26'd3) >> 18);
				if (bl_s3)
					o_s4[c] <= '0;
				else if (in_s3)
					o_s4[c] <= num[39:32];
				else
					o_s4[c] <= ov_s3[c];
			end
		end
	end

	assign rgb = {o_s4[2], o_s4[1], o_s4[0]};

endmodule

// ----- src/flow_vector_color_wheel.sv -----
// Optical-flow color wheel. Each input word carries one flow vector (signed
// fixed point with FLOW_FRAC_BITS fraction bits) and gives exactly one output
// word with an RGB color. Hue comes from the vector's angle on a 55-entry
// wheel, interpolated between neighbors; inside the unit radius (set by the
// Q16.16 register inv_max_radius, reset 1.0) the color fades toward white,
// outside it is dimmed to three quarters, and unknown flow is black. The block
// takes one word every clock cycle while the output is not stalled; the depth
// of its pipeline is set by the radius path, a 4-stage multiply and square
// pipeline followed by a 17-stage square root, which the 18-stage CORDIC
// angle path is padded to match. A stall at the output halts the whole
// pipeline in place. Write inv_max_radius only while no words are in flight.
module flow_vector_color_wheel #(
	parameter int FLOW_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // flow_x[23:0], flow_y[47:24]
	input  logic        s_tuser,  // flow_unknown
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // red[7:0], green[15:8], blue[23:16]
);

	localparam int PRE = fvcw_pkg::RADIUS_STAGES;
	localparam int PAD = fvcw_pkg::RADIUS_STAGES - fvcw_pkg::ANGLE_STAGES;
	localparam int LAT = PRE + fvcw_pkg::COLOR_STAGES;

	logic [31:0] inv_q;
	logic [LAT-1:0] vld_q;
	logic [PRE-1:0] unk_q;
	logic [fvcw_pkg::ANGLE_W-1:0] ang_q [0:PAD-1];
	logic [fvcw_pkg::ANGLE_W-1:0] ang;
	logic [fvcw_pkg::RAD_W-1:0] rad;
	logic in_unit;
	logic en;
	logic [23:0] rgb;

	// The whole pipeline advances unless a finished word waits on the output.
	assign en = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata = rgb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 32'd65536;
		end else if (cfg_wr_en) begin
			inv_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// The unknown flag and the angle ride alongside the radius path.
	always_ff @(posedge clk) begin
		if (en) begin
			unk_q <= {unk_q[PRE-2:0], s_tuser};
			ang_q[0] <= ang;
			for (int i = 1; i < PAD; i++)
				ang_q[i] <= ang_q[i-1];
		end
	end

	fvcw_angle u_angle (
		.clk    (clk),
		.en     (en),
		.flow_x (s_tdata[23:0]),
		.flow_y (s_tdata[47:24]),
		.angle  (ang)
	);

	fvcw_radius #(
		.FLOW_FRAC_BITS (FLOW_FRAC_BITS)
	) u_radius (
		.clk            (clk),
		.en             (en),
		.flow_x         (s_tdata[23:0]),
		.flow_y         (s_tdata[47:24]),
		.inv_max_radius (inv_q),
		.rad            (rad),
		.in_unit        (in_unit)
	);

	fvcw_color u_color (
		.clk     (clk),
		.en      (en),
		.angle   (ang_q[PAD-1]),
		.rad     (rad),
		.in_unit (in_unit),
		.blank   (unk_q[PRE-1]),
		.rgb     (rgb)
	);

endmodule
